/* design/rvex_pkg.sv */
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared types and codes for the RV32I execute stage: instruction formats,
// major opcodes, function codes and the branch resolution bundle.
// ----------------------------------------------------------------------------
package rvex_pkg;

    // Widths of the item fields.
    localparam int XLEN       = 32;
    localparam int KIND_W     = 3;
    localparam int OPCODE_W   = 7;
    localparam int FUNCT3_W   = 3;
    localparam int FUNCT7_W   = 7;
    localparam int SHAMT_W    = 5;

    // Instruction formats as carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_U = 3'd0;
    localparam logic [KIND_W-1:0] KIND_R = 3'd1;
    localparam logic [KIND_W-1:0] KIND_S = 3'd2;
    localparam logic [KIND_W-1:0] KIND_I = 3'd3;
    localparam logic [KIND_W-1:0] KIND_B = 3'd4;
    localparam logic [KIND_W-1:0] KIND_J = 3'd5;

    // Major opcodes that the block tells apart.
    localparam logic [OPCODE_W-1:0] OPC_LUI   = 7'b0110111;
    localparam logic [OPCODE_W-1:0] OPC_JALR  = 7'b1100111;
    localparam logic [OPCODE_W-1:0] OPC_LOAD  = 7'b0000011;
    localparam logic [OPCODE_W-1:0] OPC_OPIMM = 7'b0010011;

    // Arithmetic and logic function codes.
    localparam logic [FUNCT3_W-1:0] F3_ADD  = 3'd0;
    localparam logic [FUNCT3_W-1:0] F3_SLL  = 3'd1;
    localparam logic [FUNCT3_W-1:0] F3_SLT  = 3'd2;
    localparam logic [FUNCT3_W-1:0] F3_SLTU = 3'd3;
    localparam logic [FUNCT3_W-1:0] F3_XOR  = 3'd4;
    localparam logic [FUNCT3_W-1:0] F3_SR   = 3'd5;
    localparam logic [FUNCT3_W-1:0] F3_OR   = 3'd6;
    localparam logic [FUNCT3_W-1:0] F3_AND  = 3'd7;

    // Branch condition codes.
    localparam logic [FUNCT3_W-1:0] F3_BEQ  = 3'd0;
    localparam logic [FUNCT3_W-1:0] F3_BNE  = 3'd1;
    localparam logic [FUNCT3_W-1:0] F3_BLT  = 3'd4;
    localparam logic [FUNCT3_W-1:0] F3_BGE  = 3'd5;
    localparam logic [FUNCT3_W-1:0] F3_BLTU = 3'd6;
    localparam logic [FUNCT3_W-1:0] F3_BGEU = 3'd7;

    // Funct7 value that selects add and logical shift right.
    localparam logic [FUNCT7_W-1:0] F7_BASE = 7'b0000000;

    // Size of one instruction in bytes.
    localparam logic [XLEN-1:0] INST_BYTES = 32'd4;

    // Outcome of resolving one conditional branch.
    typedef struct packed {
        logic            is_branch;
        logic            taken;
        logic            correct;
        logic [XLEN-1:0] target;
    } branch_res_t;

endpackage

/* design/rvex_alu.sv */
// ----------------------------------------------------------------------------
// rvex_alu
// Integer arithmetic, logic, compare and shift unit shared by register and
// immediate forms of the RV32I operations.
// ----------------------------------------------------------------------------
module rvex_alu (
    input  logic [rvex_pkg::FUNCT3_W-1:0] funct3,
    input  logic                          alt,
    input  logic                          allow_sub,
    input  logic [rvex_pkg::XLEN-1:0]     op_a,
    input  logic [rvex_pkg::XLEN-1:0]     op_b,
    output logic [rvex_pkg::XLEN-1:0]     res
);
    import rvex_pkg::*;

    logic [SHAMT_W-1:0] shamt;

    // Only the low five bits of the second operand give the shift amount.
    assign shamt = op_b[SHAMT_W-1:0];

    // Operation select.
    always_comb
    begin
        unique case (funct3)
            F3_ADD:  res = (allow_sub && alt) ? (op_a - op_b) : (op_a + op_b);
            F3_SLL:  res = op_a << shamt;
            F3_SLT:  res = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
            F3_SLTU: res = {{(XLEN-1){1'b0}}, (op_a < op_b)};
            F3_XOR:  res = op_a ^ op_b;
            F3_SR:   res = alt ? XLEN'($signed(op_a) >>> shamt) : (op_a >> shamt);
            F3_OR:   res = op_a | op_b;
            F3_AND:  res = op_a & op_b;
            default: res = '0;
        endcase
    end

endmodule

/* design/rvex_branch.sv */
// ----------------------------------------------------------------------------
// rvex_branch
// Conditional branch resolution: evaluates the condition, forms the
// resolved next pc and checks it against the pc already fetched.
// ----------------------------------------------------------------------------
module rvex_branch (
    input  logic                          enable,
    input  logic [rvex_pkg::FUNCT3_W-1:0] funct3,
    input  logic [rvex_pkg::XLEN-1:0]     op_a,
    input  logic [rvex_pkg::XLEN-1:0]     op_b,
    input  logic [rvex_pkg::XLEN-1:0]     pc,
    input  logic [rvex_pkg::XLEN-1:0]     imm,
    input  logic [rvex_pkg::XLEN-1:0]     fetched_pc,
    output rvex_pkg::branch_res_t         br
);
    import rvex_pkg::*;

    logic            cond;
    logic            known;
    logic [XLEN-1:0] target;

    // Condition evaluation; the two reserved codes are not branches.
    always_comb
    begin
        known = 1'b1;
        unique case (funct3)
            F3_BEQ:  cond = (op_a == op_b);
            F3_BNE:  cond = (op_a != op_b);
            F3_BLT:  cond = ($signed(op_a) < $signed(op_b));
            F3_BGE:  cond = !($signed(op_a) < $signed(op_b));
            F3_BLTU: cond = (op_a < op_b);
            F3_BGEU: cond = !(op_a < op_b);
            default:
            begin
                cond  = 1'b0;
                known = 1'b0;
            end
        endcase
    end

    // Resolved next pc.
    assign target = cond ? (pc + imm) : (pc + INST_BYTES);

    // Fields are all zero unless a valid branch was resolved.
    always_comb
    begin
        if (enable && known)
        begin
            br.is_branch = 1'b1;
            br.taken     = cond;
            br.correct   = (fetched_pc == target);
            br.target    = target;
        end
        else
        begin
            br = '0;
        end
    end

endmodule

/* design/rv32i_execute_stage.sv */
// ----------------------------------------------------------------------------
// rv32i_execute_stage
// Execute stage of a 32-bit RISC-V integer pipeline: ALU, address
// generation, link values and conditional branch resolution.
// ----------------------------------------------------------------------------
// Usage:
//   An item is one decoded instruction. It is taken at a rising edge where
//   start is high and busy is low; busy is never raised, so an item may be
//   presented in every cycle.
//   The item is captured into an input register, evaluated by one level of
//   combinational logic (one 32-bit add or compare, a barrel shift and
//   selection) and captured into the result register.
//   The result shows after the input and result registers, marked by done
//   for exactly one cycle. Throughput: one item per cycle.
//   The receiver cannot stall; every result must be taken in the cycle
//   that done is high.
//   Reset (rst_n low, asynchronous) clears the input and result valid
//   flags, so no result appears until a new item has been accepted.
//   For items that are not conditional branches, is_branch, branch_taken,
//   prediction_correct and redirect_pc read zero.
// ----------------------------------------------------------------------------
module rv32i_execute_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rvex_pkg::KIND_W-1:0]   kind,
    input  logic [rvex_pkg::OPCODE_W-1:0] opcode,
    input  logic [rvex_pkg::FUNCT3_W-1:0] funct3,
    input  logic [rvex_pkg::FUNCT7_W-1:0] funct7,
    input  logic [rvex_pkg::XLEN-1:0]     inst_pc,
    input  logic [rvex_pkg::XLEN-1:0]     operand_a,
    input  logic [rvex_pkg::XLEN-1:0]     operand_b,
    input  logic [rvex_pkg::XLEN-1:0]     immediate,
    input  logic [rvex_pkg::XLEN-1:0]     fetched_next_pc,
    output logic                          done,
    output logic [rvex_pkg::XLEN-1:0]     result_value,
    output logic                          is_branch,
    output logic                          branch_taken,
    output logic                          prediction_correct,
    output logic [rvex_pkg::XLEN-1:0]     redirect_pc
);
    import rvex_pkg::*;

    // Input register.
    logic                in_valid_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [OPCODE_W-1:0] opcode_reg;
    logic [FUNCT3_W-1:0] funct3_reg;
    logic [FUNCT7_W-1:0] funct7_reg;
    logic [XLEN-1:0]     pc_reg;
    logic [XLEN-1:0]     a_reg;
    logic [XLEN-1:0]     b_reg;
    logic [XLEN-1:0]     imm_reg;
    logic [XLEN-1:0]     fpc_reg;

    // Result register.
    logic                done_reg;
    logic [XLEN-1:0]     result_reg;
    logic [XLEN-1:0]     result_next;
    branch_res_t         br_reg;
    branch_res_t         br_next;

    // Evaluation signals.
    logic                accept;
    logic                alt;
    logic                is_r;
    logic [XLEN-1:0]     alu_b;
    logic [XLEN-1:0]     alu_res;
    logic [XLEN-1:0]     link;

    // The stage is fully pipelined and never holds items off.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Valid flags of both register stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            opcode_reg <= opcode;
            funct3_reg <= funct3;
            funct7_reg <= funct7;
            pc_reg     <= inst_pc;
            a_reg      <= operand_a;
            b_reg      <= operand_b;
            imm_reg    <= immediate;
            fpc_reg    <= fetched_next_pc;
        end
    end

    // Shared ALU: register form takes rs2, immediate form the immediate.
    assign is_r  = (kind_reg == KIND_R);
    assign alt   = (funct7_reg != F7_BASE);
    assign alu_b = is_r ? b_reg : imm_reg;

    rvex_alu u_alu (
        .funct3    (funct3_reg),
        .alt       (alt),
        .allow_sub (is_r),
        .op_a      (a_reg),
        .op_b      (alu_b),
        .res       (alu_res)
    );

    // Branch resolution.
    rvex_branch u_branch (
        .enable     (kind_reg == KIND_B),
        .funct3     (funct3_reg),
        .op_a       (a_reg),
        .op_b       (b_reg),
        .pc         (pc_reg),
        .imm        (imm_reg),
        .fetched_pc (fpc_reg),
        .br         (br_next)
    );

    assign link = pc_reg + INST_BYTES;

    // Result selection by instruction format.
    always_comb
    begin
        unique case (kind_reg)
            KIND_U: result_next = (opcode_reg == OPC_LUI) ? imm_reg : (pc_reg + imm_reg);
            KIND_R: result_next = alu_res;
            KIND_S: result_next = a_reg + imm_reg;
            KIND_I:
            begin
                priority if (opcode_reg == OPC_JALR)
                    result_next = link;
                else if (opcode_reg == OPC_LOAD)
                    result_next = a_reg + imm_reg;
                else if (opcode_reg == OPC_OPIMM)
                    result_next = alu_res;
                else
                    result_next = '0;
            end
            KIND_B: result_next = {{(XLEN-1){1'b0}}, br_next.taken};
            KIND_J: result_next = link;
            default: result_next = '0;
        endcase
    end

    // Result capture.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= result_next;
            br_reg     <= br_next;
        end
    end

    assign done               = done_reg;
    assign result_value       = result_reg;
    assign is_branch          = br_reg.is_branch;
    assign branch_taken       = br_reg.taken;
    assign prediction_correct = br_reg.correct;
    assign redirect_pc        = br_reg.target;

endmodule

/* design/rvex_checker.sv */
// ----------------------------------------------------------------------------
// rvex_checker
// Port-level checks for the execute stage: fixed latency, no stalls and
// consistency of the branch outputs.
// ----------------------------------------------------------------------------
module rvex_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [rvex_pkg::XLEN-1:0]     result_value,
    input logic                          is_branch,
    input logic                          branch_taken,
    input logic                          prediction_correct,
    input logic [rvex_pkg::XLEN-1:0]     redirect_pc
);
    import rvex_pkg::*;

    // The stage never refuses an item.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // Every accepted item yields its result after the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after acceptance");

    // No result appears without an item accepted ahead of it through both registers.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##2 !done)
        else $error("result without an accepted item");

    // Non-branch results carry no branch information.
    a_nonbranch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !is_branch) |->
            (!branch_taken && !prediction_correct && redirect_pc == '0))
        else $error("branch fields set on a non-branch result");

    // A branch result value is its condition bit.
    a_branch_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_branch) |->
            (result_value == {{(XLEN-1){1'b0}}, branch_taken}))
        else $error("branch result value differs from taken flag");

endmodule

bind rv32i_execute_stage rvex_checker u_rvex_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .done               (done),
    .result_value       (result_value),
    .is_branch          (is_branch),
    .branch_taken       (branch_taken),
    .prediction_correct (prediction_correct),
    .redirect_pc        (redirect_pc)
);
